[rtl/mfbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mfbp_pkg;

	localparam int MAX_FIELD_BITS = 32;
	localparam int VALUE_BITS     = 32;
	localparam int BYTE_BITS      = 8;
	localparam int IDX_W          = 6;
	localparam int FIELD_LIM      = (MAX_FIELD_BITS < VALUE_BITS) ? MAX_FIELD_BITS : VALUE_BITS;
	localparam int IN_W           = 40;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_MIN   = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// One bit step handed from the serializer to the byte assembler.
	typedef struct packed {
		logic valid;
		logic flush;
		logic write;
		logic data;
		logic last;
	} beat_t;

endpackage
`default_nettype wire

[rtl/mfbp_serializer.sv]
`timescale 1ns / 1ps
`default_nettype none
module mfbp_serializer #(
	parameter int MAX_FIELD_BITS = mfbp_pkg::MAX_FIELD_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  op,
	input  wire logic [mfbp_pkg::IDX_W-1:0]  bit_count,
	input  wire logic [mfbp_pkg::VALUE_BITS-1:0] value,
	output mfbp_pkg::beat_t                  beat,
	input  wire logic                        beat_ready
);

	localparam int                         LIM_I  = (MAX_FIELD_BITS < mfbp_pkg::VALUE_BITS)
		? MAX_FIELD_BITS : mfbp_pkg::VALUE_BITS;
	localparam logic [mfbp_pkg::IDX_W-1:0] LIM    = mfbp_pkg::IDX_W'(LIM_I);
	localparam logic [mfbp_pkg::IDX_W-1:0] VBITS  = mfbp_pkg::IDX_W'(mfbp_pkg::VALUE_BITS);
	localparam logic [mfbp_pkg::IDX_W-1:0] BBITS  = mfbp_pkg::IDX_W'(mfbp_pkg::BYTE_BITS);
	localparam logic [mfbp_pkg::IDX_W-1:0] ONE    = mfbp_pkg::IDX_W'(1);

	logic                             busy_q;
	logic                             flush_q;
	logic                             min_q;
	logic                             seen_q;
	logic [mfbp_pkg::IDX_W-1:0]       idx_q;
	logic [mfbp_pkg::VALUE_BITS-1:0]  sh_q;
	logic [mfbp_pkg::IDX_W-1:0]       cnt;
	logic                             load;
	logic                             step;

	assign in_ready = !busy_q;
	assign load     = in_valid && !busy_q;
	assign step     = busy_q && beat_ready;
	assign cnt      = (bit_count > LIM) ? LIM : bit_count;

	// The bit under the head of the shift register is written only once it lies within the
	// field limit and, for a minimal-width item, at or below the first one.
	always_comb begin
		beat.valid = busy_q;
		beat.flush = flush_q;
		beat.data  = sh_q[mfbp_pkg::VALUE_BITS-1];
		beat.write = !flush_q && (idx_q <= LIM)
			&& (!min_q || seen_q || sh_q[mfbp_pkg::VALUE_BITS-1]);
		beat.last  = idx_q <= BBITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			flush_q <= 1'b0;
			min_q   <= 1'b0;
			seen_q  <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			seen_q <= 1'b0;
			unique case (op)
				mfbp_pkg::OP_WRITE: begin
					busy_q  <= cnt != '0;
					flush_q <= 1'b0;
					min_q   <= 1'b0;
					idx_q   <= cnt;
				end
				mfbp_pkg::OP_MIN: begin
					busy_q  <= 1'b1;
					flush_q <= 1'b0;
					min_q   <= 1'b1;
					idx_q   <= VBITS;
				end
				mfbp_pkg::OP_FLUSH: begin
					busy_q  <= 1'b1;
					flush_q <= 1'b1;
					min_q   <= 1'b0;
					idx_q   <= ONE;
				end
				default: begin
					busy_q <= 1'b0;
				end
			endcase
		end else if (step) begin
			seen_q <= seen_q || sh_q[mfbp_pkg::VALUE_BITS-1];
			idx_q  <= idx_q - ONE;
			if (idx_q == ONE) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (op == mfbp_pkg::OP_WRITE) begin
				sh_q <= value << (VBITS - cnt);
			end else begin
				sh_q <= value;
			end
		end else if (step) begin
			sh_q <= {sh_q[mfbp_pkg::VALUE_BITS-2:0], 1'b0};
		end
	end

endmodule
`default_nettype wire

[rtl/mfbp_byte_asm.sv]
`timescale 1ns / 1ps
`default_nettype none
module mfbp_byte_asm (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mfbp_pkg::beat_t               beat,
	output logic                               beat_ready,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mfbp_pkg::BYTE_BITS-1:0]     out_byte,
	output logic                               out_last
);

	localparam int POS_W = $clog2(mfbp_pkg::BYTE_BITS);
	localparam logic [POS_W-1:0] POS_TOP = POS_W'(mfbp_pkg::BYTE_BITS - 1);

	logic [mfbp_pkg::BYTE_BITS-1:0] part_q;
	logic [POS_W-1:0]               pos_q;
	logic [mfbp_pkg::BYTE_BITS-1:0] byte_q;
	logic                           last_q;
	logic                           valid_q;
	logic                           out_free;
	logic                           take;
	logic [mfbp_pkg::BYTE_BITS-1:0] merged;
	logic                           emit;

	assign out_free   = !valid_q || out_ready;
	assign beat_ready = beat.flush ? out_free : (!beat.write || pos_q != POS_TOP || out_free);
	assign take       = beat.valid && beat_ready;
	assign merged     = part_q | ({beat.data, {(mfbp_pkg::BYTE_BITS-1){1'b0}}} >> pos_q);
	assign emit       = take && (beat.flush ? (pos_q != '0) : (beat.write && pos_q == POS_TOP));

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q  <= '0;
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (take && (beat.flush || beat.write)) begin
				if (beat.flush || pos_q == POS_TOP) begin
					part_q <= '0;
					pos_q  <= '0;
				end else begin
					part_q <= merged;
					pos_q  <= pos_q + POS_W'(1);
				end
			end
		end
	end

	// A flush always ends its item, so it always carries the last mark.
	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= beat.flush ? part_q : merged;
			last_q <= beat.flush || beat.last;
		end
	end

endmodule
`default_nettype wire

[rtl/msb_first_bit_packer.sv]
// Each input beat is taken only while the serializer is idle; the serializer then scans
// bit_count (capped) bits for a fixed-width write, 32 for a minimal-width write, one for
// a flush. Its shift register moves one bit a cycle while the byte assembler takes beats,
// and s_tready is low while an item is scanned. Bytes leave through a one-entry output register.
// Reset: arst_n clears the open byte, the bit position and all valid flags at once.
`timescale 1ns / 1ps
`default_nettype none
module msb_first_bit_packer #(
	parameter int MAX_FIELD_BITS = mfbp_pkg::MAX_FIELD_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [mfbp_pkg::IN_W-1:0]   s_tdata,  // op[1:0], bit_count[7:2], value[39:8]
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [mfbp_pkg::BYTE_BITS-1:0]   m_tdata,  // byte_out[7:0]
	output logic                             m_tlast
);

	mfbp_pkg::beat_t beat;
	logic            beat_ready;

	mfbp_serializer #(
		.MAX_FIELD_BITS (MAX_FIELD_BITS)
	) u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.op         (s_tdata[1:0]),
		.bit_count  (s_tdata[7:2]),
		.value      (s_tdata[39:8]),
		.beat       (beat),
		.beat_ready (beat_ready)
	);

	mfbp_byte_asm u_asm (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat       (beat),
		.beat_ready (beat_ready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_last   (m_tlast)
	);

endmodule
`default_nettype wire

[rtl/mfbp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module mfbp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_tvalid,
	input wire logic                        s_tready,
	input wire logic [mfbp_pkg::IN_W-1:0]   s_tdata,
	input wire logic                        m_tvalid,
	input wire logic                        m_tready,
	input wire logic [mfbp_pkg::BYTE_BITS-1:0] m_tdata,
	input wire logic                        m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat dropped or changed while stalled");

	// An unused op leaves the block free in the next cycle.
	a_none_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] == mfbp_pkg::OP_NONE |=> s_tready)
		else $error("unused op occupied the block");

	// A zero-width fixed write does no work.
	a_zero_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] == mfbp_pkg::OP_WRITE && s_tdata[7:2] == 6'd0
		|=> s_tready)
		else $error("zero-width write occupied the block");

	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] == mfbp_pkg::OP_FLUSH |=> !s_tready)
		else $error("flush did not occupy the block");

endmodule

bind msb_first_bit_packer mfbp_checker u_mfbp_checker (.*);
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb;

	localparam int IDLE_LIMIT   = 3000;
	localparam int SETTLE_TICKS = 80;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} packed_byte_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;  // op[1:0], bit_count[7:2], value[39:8]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // byte_out[7:0]
	logic        m_tlast;

	msb_first_bit_packer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// Predictor state: the open byte and how many of its bits are filled.
	logic [7:0]   open_byte = '0;
	logic [2:0]   fill_bits = '0;
	packed_byte_t pending_bytes[$];

	int mismatch_count = 0;
	int burst_left     = 0;
	int idle_cycles    = 0;
	int ready_cycle    = 0;

	function automatic int field_length(input logic [31:0] value);
		int n;
		n = 0;
		for (int i = 0; i < 32; i++) begin
			if (value[i]) n = i + 1;
		end
		return n;
	endfunction

	task automatic pack_bits(input logic [1:0] op, input logic [5:0] count,
			input logic [31:0] value);
		int           n;
		int           emitted;
		packed_byte_t b;
		emitted = 0;
		if (op == mfbp_pkg::OP_FLUSH) begin
			if (fill_bits != 0) begin
				b.data = open_byte;
				b.last = 1'b1;
				pending_bytes.push_back(b);
				open_byte = '0;
				fill_bits = '0;
			end
		end else if (op != mfbp_pkg::OP_NONE) begin
			n = (op == mfbp_pkg::OP_MIN) ? field_length(value) : int'(count);
			if (n > mfbp_pkg::FIELD_LIM) n = mfbp_pkg::FIELD_LIM;
			for (int i = n; i > 0; i--) begin
				if (value[i-1]) open_byte[7 - fill_bits] = 1'b1;
				if (fill_bits == 3'd7) begin
					b.data = open_byte;
					b.last = 1'b0;
					pending_bytes.push_back(b);
					emitted++;
					open_byte = '0;
					fill_bits = '0;
				end else begin
					fill_bits = fill_bits + 3'd1;
				end
			end
			if (emitted > 0) pending_bytes[pending_bytes.size() - 1].last = 1'b1;
		end
	endtask

	// The sender works in bursts; between bursts tvalid drops for a random gap.
	task automatic send_field(input logic [1:0] op, input logic [5:0] count,
			input logic [31:0] value);
		int gap;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {value, count, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pack_bits(op, count, value);
		burst_left--;
	endtask

	task automatic wait_for_drain();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return mfbp_pkg::OP_WRITE;
		if (r < 75) return mfbp_pkg::OP_MIN;
		if (r < 88) return mfbp_pkg::OP_FLUSH;
		return mfbp_pkg::OP_NONE;
	endfunction

	function automatic logic [5:0] pick_count();
		if ($urandom_range(0, 6) == 0) return 6'($urandom_range(0, 63));
		return 6'($urandom_range(0, 32));
	endfunction

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 1) == 0) return $urandom >> $urandom_range(0, 31);
		return $urandom;
	endfunction

	task automatic test_directed();
		send_field(mfbp_pkg::OP_WRITE, 6'd32, 32'hFFFF_FFFF);
		send_field(mfbp_pkg::OP_WRITE, 6'd32, 32'h0000_0000);
		send_field(mfbp_pkg::OP_WRITE, 6'd0,  32'hDEAD_BEEF);
		send_field(mfbp_pkg::OP_WRITE, 6'd1,  32'h0000_0001);
		send_field(mfbp_pkg::OP_WRITE, 6'd7,  32'h0000_0055);
		send_field(mfbp_pkg::OP_WRITE, 6'd32, 32'hA5C3_0F96);
		send_field(mfbp_pkg::OP_WRITE, 6'd63, 32'h8000_0001);
		send_field(mfbp_pkg::OP_WRITE, 6'd33, 32'h1234_5678);
		send_field(mfbp_pkg::OP_WRITE, 6'd4,  32'hFFFF_FFF5);
		send_field(mfbp_pkg::OP_FLUSH, 6'd0,  32'h0000_0000);
		send_field(mfbp_pkg::OP_FLUSH, 6'd63, 32'hFFFF_FFFF);
		send_field(mfbp_pkg::OP_MIN,   6'd0,  32'h0000_0000);
		send_field(mfbp_pkg::OP_MIN,   6'd63, 32'h0000_0001);
		send_field(mfbp_pkg::OP_MIN,   6'd5,  32'hFFFF_FFFF);
		send_field(mfbp_pkg::OP_MIN,   6'd0,  32'h0000_0100);
		send_field(mfbp_pkg::OP_NONE,  6'd32, 32'hFFFF_FFFF);
		send_field(mfbp_pkg::OP_NONE,  6'd0,  32'h0000_0000);
		send_field(mfbp_pkg::OP_WRITE, 6'd3,  32'h0000_0005);
		send_field(mfbp_pkg::OP_NONE,  6'd63, 32'h5555_5555);
		send_field(mfbp_pkg::OP_FLUSH, 6'd0,  32'h0000_0000);
		send_field(mfbp_pkg::OP_WRITE, 6'd8,  32'h0000_00C3);
		send_field(mfbp_pkg::OP_FLUSH, 6'd0,  32'h0000_0000);
	endtask

	// A partial byte is left open, the bus goes quiet until all bytes are
	// out, and only then is the byte flushed.
	task automatic test_flush_after_idle();
		send_field(mfbp_pkg::OP_WRITE, 6'd13, 32'h0000_1ABC);
		send_field(mfbp_pkg::OP_MIN,   6'd0,  32'h0000_002D);
		wait_for_drain();
		send_field(mfbp_pkg::OP_FLUSH, 6'd0,  32'h0000_0000);
		wait_for_drain();
	endtask

	task automatic test_random_fields();
		for (int i = 0; i < 330; i++) send_field(pick_op(), pick_count(), pick_value());
	endtask

	// Runs of writes that are closed by a flush, with an ignored op now and then.
	task automatic test_framed_runs();
		int run_len;
		for (int f = 0; f < 25; f++) begin
			run_len = $urandom_range(1, 8);
			for (int i = 0; i < run_len; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_field(mfbp_pkg::OP_NONE, pick_count(), pick_value());
				else if ($urandom_range(0, 1) == 0)
					send_field(mfbp_pkg::OP_WRITE, pick_count(), pick_value());
				else
					send_field(mfbp_pkg::OP_MIN, pick_count(), pick_value());
			end
			send_field(mfbp_pkg::OP_FLUSH, pick_count(), pick_value());
		end
	endtask

	// The receiver cycles through four stall patterns, selected by bits 7:6 of ready_cycle.
	always @(posedge clk) begin
		ready_cycle <= ready_cycle + 1;
		case (ready_cycle[7:6])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= 1'($urandom_range(0, 1));
			2'd2: m_tready <= (ready_cycle[1:0] == 2'd0);
			default: m_tready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		packed_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected byte: data=%02h last=%0b", m_tdata, m_tlast);
			end else begin
				want = pending_bytes.pop_front();
				if (m_tdata !== want.data || m_tlast !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("byte mismatch: expected data=%02h last=%0b, got data=%02h last=%0b",
							want.data, want.last, m_tdata, m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_flush_after_idle();
		test_random_fields();
		test_framed_runs();
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
		if (mismatch_count == 0 && pending_bytes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
rtl/mfbp_pkg.sv
rtl/mfbp_serializer.sv
rtl/mfbp_byte_asm.sv
rtl/msb_first_bit_packer.sv
rtl/mfbp_checker.sv
bench/tb.sv
